### sv/esd_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and lookup functions for the escape sequence decoder
// no dependencies; used by every other file of the block but esd_if

package esd_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_SLASH = 3'd1,
        MODE_HEXX  = 3'd2,
        MODE_HEXU4 = 3'd3,
        MODE_HEXU8 = 3'd4,
        MODE_OCT   = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_EMPTY_X = 3'd1,
        ST_SHORT_U = 3'd2,
        ST_SHORT_W = 3'd3,
        ST_UNKNOWN = 3'd4
    } status_t;

    localparam logic [3:0] LIMIT_HEXX  = 4'd8;
    localparam logic [3:0] LIMIT_HEXU4 = 4'd4;
    localparam logic [3:0] LIMIT_HEXU8 = 4'd8;
    localparam logic [3:0] LIMIT_OCT   = 4'd11;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    typedef struct packed {
        logic [31:0] out_value;
        logic        is_code_point;
        logic [2:0]  status;
        logic        end_of_string;
    } result_t;

    // up to two results produced by one request
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

    typedef struct packed {
        logic    valid;
        logic    slash;
        result_t res;
    } plain_t;

    // {valid, digit value}
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h61 + 8'h0A)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h41 + 8'h0A)};
        end
        return r;
    endfunction

    // {valid, control byte}
    function automatic logic [8:0] letter_code(input logic [7:0] b);
        logic [8:0] r;
        r = 9'd0;
        unique case (b)
            8'h6E:   r = {1'b1, 8'h0A};
            8'h74:   r = {1'b1, 8'h09};
            8'h76:   r = {1'b1, 8'h0B};
            8'h62:   r = {1'b1, 8'h08};
            8'h72:   r = {1'b1, 8'h0D};
            8'h66:   r = {1'b1, 8'h0C};
            8'h61:   r = {1'b1, 8'h07};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h3F:   r = {1'b1, 8'h3F};
            8'h27:   r = {1'b1, 8'h27};
            8'h22:   r = {1'b1, 8'h22};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic is_octal(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h37);
    endfunction

    function automatic result_t make_result(input logic [31:0] value, input logic cp,
                                            input status_t st, input logic fin);
        result_t r;
        r.out_value     = value;
        r.is_code_point = cp;
        r.status        = st;
        r.end_of_string = fin;
        return r;
    endfunction

    // byte seen with no escape pending
    function automatic plain_t plain_byte(input logic [7:0] b, input logic fin);
        plain_t p;
        p.valid = 1'b0;
        p.slash = 1'b0;
        p.res   = make_result(32'd0, 1'b0, ST_OK, fin);
        if (b == CH_BACKSLASH) begin
            if (fin) begin
                p.valid = 1'b1;
                p.res   = make_result(32'd0, 1'b0, ST_UNKNOWN, 1'b1);
            end else begin
                p.slash = 1'b1;
            end
        end else begin
            p.valid = 1'b1;
            p.res   = make_result({24'd0, b}, 1'b0, ST_OK, fin);
        end
        return p;
    endfunction

endpackage

### sv/esd_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces for the byte input and the result output
// no dependencies

interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       final_byte;

    modport source (output valid, output text_byte, output final_byte, input ready);
    modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface esd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_value;
    logic        is_code_point;
    logic [2:0]  status;
    logic        end_of_string;

    modport source (output valid, output out_value, output is_code_point,
                    output status, output end_of_string, input ready);
    modport sink   (input valid, input out_value, input is_code_point,
                    input status, input end_of_string, output ready);
endinterface

### sv/esd_decode.sv
`timescale 1ns / 1ps
// escape state registers and the per-byte decode logic
// depends on esd_pkg

module esd_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [7:0]         text_byte,
    input  logic               final_byte,
    output esd_pkg::push_t     push
);

    esd_pkg::mode_t mode_reg, mode_next;
    logic [3:0]     cnt_reg, cnt_next;
    logic [31:0]    acc_reg, acc_next;
    logic           skip_reg, skip_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= esd_pkg::MODE_IDLE;
            cnt_reg  <= 4'd0;
            acc_reg  <= 32'd0;
            skip_reg <= 1'b0;
        end
        else if (take)
        begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            acc_reg  <= acc_next;
            skip_reg <= skip_next;
        end
    end

    always_comb
    begin
        logic [4:0]       hx;
        logic [8:0]       lc;
        logic [31:0]      hex_sum;
        logic [31:0]      oct_sum;
        logic [3:0]       cnt_inc;
        logic [3:0]       limit;
        esd_pkg::status_t short_st;
        esd_pkg::plain_t  pb;

        hx       = esd_pkg::hex_digit(text_byte);
        lc       = esd_pkg::letter_code(text_byte);
        hex_sum  = {acc_reg[27:0], hx[3:0]};
        oct_sum  = {acc_reg[28:0], text_byte[2:0]};
        cnt_inc  = cnt_reg + 4'd1;
        pb       = esd_pkg::plain_byte(text_byte, final_byte);
        short_st = (mode_reg == esd_pkg::MODE_HEXU4) ? esd_pkg::ST_SHORT_U
                                                     : esd_pkg::ST_SHORT_W;
        unique case (mode_reg)
            esd_pkg::MODE_HEXX:  limit = esd_pkg::LIMIT_HEXX;
            esd_pkg::MODE_HEXU4: limit = esd_pkg::LIMIT_HEXU4;
            default:             limit = esd_pkg::LIMIT_HEXU8;
        endcase

        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        skip_next = skip_reg;
        push      = '0;

        if (skip_reg)
        begin
            if (final_byte)
                skip_next = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                esd_pkg::MODE_SLASH:
                begin
                    acc_next = 32'd0;
                    cnt_next = 4'd0;
                    if (lc[8])
                    begin
                        push.v0   = 1'b1;
                        push.r0   = esd_pkg::make_result({24'd0, lc[7:0]}, 1'b0,
                                                         esd_pkg::ST_OK, final_byte);
                        mode_next = esd_pkg::MODE_IDLE;
                    end
                    else if (text_byte == 8'h78 || text_byte == 8'h75 || text_byte == 8'h55)
                    begin
                        if (final_byte)
                        begin
                            push.v0   = 1'b1;
                            push.r0   = esd_pkg::make_result(32'd0, 1'b0,
                                (text_byte == 8'h78) ? esd_pkg::ST_EMPTY_X :
                                (text_byte == 8'h75) ? esd_pkg::ST_SHORT_U :
                                                       esd_pkg::ST_SHORT_W, 1'b1);
                            mode_next = esd_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            mode_next = (text_byte == 8'h78) ? esd_pkg::MODE_HEXX :
                                        (text_byte == 8'h75) ? esd_pkg::MODE_HEXU4 :
                                                               esd_pkg::MODE_HEXU8;
                        end
                    end
                    else if (esd_pkg::is_octal(text_byte))
                    begin
                        if (final_byte)
                        begin
                            push.v0   = 1'b1;
                            push.r0   = esd_pkg::make_result({29'd0, text_byte[2:0]}, 1'b1,
                                                             esd_pkg::ST_OK, 1'b1);
                            mode_next = esd_pkg::MODE_IDLE;
                        end
                        else
                        begin
                            acc_next  = {29'd0, text_byte[2:0]};
                            cnt_next  = 4'd1;
                            mode_next = esd_pkg::MODE_OCT;
                        end
                    end
                    else
                    begin
                        push.v0   = 1'b1;
                        push.r0   = esd_pkg::make_result(32'd0, 1'b0, esd_pkg::ST_UNKNOWN,
                                                         final_byte);
                        mode_next = esd_pkg::MODE_IDLE;
                        skip_next = !final_byte;
                    end
                end

                esd_pkg::MODE_HEXX, esd_pkg::MODE_HEXU4, esd_pkg::MODE_HEXU8:
                begin
                    if (hx[4])
                    begin
                        if (cnt_inc >= limit ||
                            (final_byte && mode_reg == esd_pkg::MODE_HEXX))
                        begin
                            push.v0   = 1'b1;
                            push.r0   = esd_pkg::make_result(hex_sum, 1'b1, esd_pkg::ST_OK,
                                                             final_byte);
                            mode_next = esd_pkg::MODE_IDLE;
                            cnt_next  = 4'd0;
                            acc_next  = 32'd0;
                        end
                        else if (final_byte)
                        begin
                            push.v0   = 1'b1;
                            push.r0   = esd_pkg::make_result(32'd0, 1'b0, short_st, 1'b1);
                            mode_next = esd_pkg::MODE_IDLE;
                            cnt_next  = 4'd0;
                            acc_next  = 32'd0;
                            skip_next = 1'b0;
                        end
                        else
                        begin
                            acc_next = hex_sum;
                            cnt_next = cnt_inc;
                        end
                    end
                    else if (mode_reg == esd_pkg::MODE_HEXX && cnt_reg != 4'd0)
                    begin
                        // run cut by a non-digit: code point, then the byte itself
                        push.v0   = 1'b1;
                        push.r0   = esd_pkg::make_result(acc_reg, 1'b1, esd_pkg::ST_OK, 1'b0);
                        push.v1   = pb.valid;
                        push.r1   = pb.res;
                        mode_next = pb.slash ? esd_pkg::MODE_SLASH : esd_pkg::MODE_IDLE;
                        cnt_next  = 4'd0;
                        acc_next  = 32'd0;
                    end
                    else
                    begin
                        push.v0   = 1'b1;
                        push.r0   = esd_pkg::make_result(32'd0, 1'b0,
                            (mode_reg == esd_pkg::MODE_HEXX) ? esd_pkg::ST_EMPTY_X : short_st,
                            final_byte);
                        mode_next = esd_pkg::MODE_IDLE;
                        cnt_next  = 4'd0;
                        acc_next  = 32'd0;
                        skip_next = !final_byte;
                    end
                end

                esd_pkg::MODE_OCT:
                begin
                    if (esd_pkg::is_octal(text_byte))
                    begin
                        if (cnt_inc >= esd_pkg::LIMIT_OCT || final_byte)
                        begin
                            push.v0   = 1'b1;
                            push.r0   = esd_pkg::make_result(oct_sum, 1'b1, esd_pkg::ST_OK,
                                                             final_byte);
                            mode_next = esd_pkg::MODE_IDLE;
                            cnt_next  = 4'd0;
                            acc_next  = 32'd0;
                        end
                        else
                        begin
                            acc_next = oct_sum;
                            cnt_next = cnt_inc;
                        end
                    end
                    else
                    begin
                        push.v0   = 1'b1;
                        push.r0   = esd_pkg::make_result(acc_reg, 1'b1, esd_pkg::ST_OK, 1'b0);
                        push.v1   = pb.valid;
                        push.r1   = pb.res;
                        mode_next = pb.slash ? esd_pkg::MODE_SLASH : esd_pkg::MODE_IDLE;
                        cnt_next  = 4'd0;
                        acc_next  = 32'd0;
                    end
                end

                default:
                begin
                    push.v0   = pb.valid;
                    push.r0   = pb.res;
                    mode_next = pb.slash ? esd_pkg::MODE_SLASH : esd_pkg::MODE_IDLE;
                    cnt_next  = 4'd0;
                    acc_next  = 32'd0;
                end
            endcase
        end
    end

endmodule

### sv/esd_result_queue.sv
`timescale 1ns / 1ps
// small result queue taking up to two results per cycle, one out per cycle
// depends on esd_pkg and esd_if

module esd_result_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  esd_pkg::push_t push,
    output logic           room,
    esd_out_if.source      result
);

    esd_pkg::result_t                 entry_reg [esd_pkg::QUEUE_DEPTH];
    logic [esd_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [esd_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [esd_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic [esd_pkg::QCNT_W-1:0]       n_push;
    logic                             pop;
    esd_pkg::result_t                 head;

    assign pop    = result.valid && result.ready;
    // slot 1 is only filled when slot 0 is
    assign n_push = take ? (esd_pkg::QCNT_W'(push.v0) + esd_pkg::QCNT_W'(push.v1))
                         : '0;
    assign room   = count_reg <= esd_pkg::QCNT_W'(esd_pkg::QUEUE_DEPTH - 2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + esd_pkg::QPTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + esd_pkg::QPTR_W'(pop);
        count_next  = count_reg + n_push - esd_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && push.v0)
            entry_reg[wr_ptr_reg] <= push.r0;
        if (take && push.v1)
            entry_reg[wr_ptr_reg + esd_pkg::QPTR_W'(1)] <= push.r1;
    end

    assign head                 = entry_reg[rd_ptr_reg];
    assign result.valid         = count_reg != '0;
    assign result.out_value     = head.out_value;
    assign result.is_code_point = head.is_code_point;
    assign result.status        = head.status;
    assign result.end_of_string = head.end_of_string;

endmodule

### sv/escape_sequence_decoder_unit.sv
`timescale 1ns / 1ps
// escape sequence decoder: one literal byte per request in, decoded results out
// when the queue is empty, the first result of an accepted byte is offered in the cycle after it
// throughput: one byte per cycle; a byte that yields two results puts both in the queue, which hands them
// out one at a time, and ready drops while the four-entry queue has under two free slots
// reset (async, active low) returns the escape state to idle and empties the queue

module escape_sequence_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    esd_in_if.sink     text,
    esd_out_if.source  result
);

    logic           take;
    logic           room;
    esd_pkg::push_t push;

    assign text.ready = room;
    assign take       = text.valid && room;

    esd_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .text_byte  (text.text_byte),
        .final_byte (text.final_byte),
        .push       (push)
    );

    esd_result_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .push   (push),
        .room   (room),
        .result (result)
    );

endmodule

### sv/esd_checker.sv
`timescale 1ns / 1ps
// port-level checks for the escape sequence decoder, bound to the top level
// depends on esd_pkg and escape_sequence_decoder_unit

module esd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic [31:0] out_value,
    input logic        is_code_point,
    input logic [2:0]  status,
    input logic        end_of_string
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(out_value) &&
            $stable(is_code_point) && $stable(status) && $stable(end_of_string))
        else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && status != esd_pkg::ST_OK |-> out_value == 32'd0 && !is_code_point)
        else $error("error result carries a value");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !is_code_point |-> out_value[31:8] == 24'd0)
        else $error("raw byte wider than eight bits");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> status == esd_pkg::ST_OK || status == esd_pkg::ST_EMPTY_X ||
            status == esd_pkg::ST_SHORT_U || status == esd_pkg::ST_SHORT_W ||
            status == esd_pkg::ST_UNKNOWN)
        else $error("status code out of range");

endmodule

bind escape_sequence_decoder_unit esd_checker u_esd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .out_value     (result.out_value),
    .is_code_point (result.is_code_point),
    .status        (result.status),
    .end_of_string (result.end_of_string)
);

### bench/escape_sequence_decoder_unit_tb.sv
`timescale 1ns / 1ps
// self-checking bench for escape_sequence_decoder_unit: literal bytes in, decoded results
// checked against a decoder kept in the bench; needs esd_pkg, esd_in_if and esd_out_if

module escape_sequence_decoder_unit_tb;

    typedef struct {
        logic [7:0] text_byte;
        logic       final_byte;
        int         gap;
        bit         drain;
    } text_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    esd_in_if  text_if ();
    esd_out_if res_if ();

    escape_sequence_decoder_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_if),
        .result (res_if)
    );

    logic       drv_valid = 1'b0;
    logic [7:0] drv_byte  = 8'd0;
    logic       drv_fin   = 1'b0;
    logic       res_ready = 1'b0;

    assign text_if.valid      = drv_valid;
    assign text_if.text_byte  = drv_byte;
    assign text_if.final_byte = drv_fin;
    assign res_if.ready       = res_ready;

    // pending requests and the decoded results they are due to produce
    text_req_t         text_reqs[$];
    esd_pkg::result_t  due_results[$];
    logic [7:0]        lit_bytes[$];

    // decoder state as the bench tracks it
    esd_pkg::mode_t esc_mode     = esd_pkg::MODE_IDLE;
    logic [3:0]     digits_taken = 4'd0;
    logic [31:0]    code_acc     = 32'd0;
    logic           skipping     = 1'b0;

    logic      in_fire   = 1'b0;
    logic      out_fire  = 1'b0;
    bit        have_next = 1'b0;
    text_req_t next_req;
    int        send_hold = 0;
    int        ready_hold = 0;
    bit        sink_calm = 1'b0;

    int bytes_taken     = 0;
    int results_checked = 0;
    int code_points     = 0;
    int error_results   = 0;
    int literal_count   = 0;
    int mismatches      = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic expect_result(input logic [31:0] value, input logic cp,
                                 input esd_pkg::status_t st, input logic fin);
        esd_pkg::result_t r;
        r.out_value     = value;
        r.is_code_point = cp;
        r.status        = st;
        r.end_of_string = fin;
        due_results.push_back(r);
    endtask

    task automatic clear_escape();
        esc_mode     = esd_pkg::MODE_IDLE;
        digits_taken = 4'd0;
        code_acc     = 32'd0;
    endtask

    task automatic raise_error(input esd_pkg::status_t st, input logic fin);
        expect_result(32'd0, 1'b0, st, fin);
        clear_escape();
        skipping = !fin;
    endtask

    task automatic emit_code(input logic fin);
        expect_result(code_acc, 1'b1, esd_pkg::ST_OK, fin);
        clear_escape();
    endtask

    task automatic take_plain(input logic [7:0] b, input logic fin);
        if (b == esd_pkg::CH_BACKSLASH)
        begin
            if (fin)
                raise_error(esd_pkg::ST_UNKNOWN, 1'b1);
            else
                esc_mode = esd_pkg::MODE_SLASH;
        end
        else
        begin
            expect_result({24'd0, b}, 1'b0, esd_pkg::ST_OK, fin);
        end
    endtask

    // advance the tracked decoder by one accepted byte, queueing what it must emit
    task automatic decode_byte(input logic [7:0] b, input logic fin);
        logic [8:0]        ctl;
        logic [4:0]        nib;
        logic              is_oct;
        logic [3:0]        lim;
        esd_pkg::status_t  short_st;
        case (b)
            "n":     ctl = {1'b1, 8'h0A};
            "t":     ctl = {1'b1, 8'h09};
            "v":     ctl = {1'b1, 8'h0B};
            "b":     ctl = {1'b1, 8'h08};
            "r":     ctl = {1'b1, 8'h0D};
            "f":     ctl = {1'b1, 8'h0C};
            "a":     ctl = {1'b1, 8'h07};
            "\\":    ctl = {1'b1, 8'h5C};
            "?":     ctl = {1'b1, 8'h3F};
            "'":     ctl = {1'b1, 8'h27};
            "\"":    ctl = {1'b1, 8'h22};
            default: ctl = 9'd0;
        endcase
        // letters a-f / A-F have low nibble 1..6, value is that plus nine
        nib = 5'd0;
        if (b >= "0" && b <= "9")
            nib = {1'b1, b[3:0]};
        else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F"))
            nib = {1'b1, b[3:0] + 4'd9};
        is_oct   = (b >= "0") && (b <= "7");
        lim      = (esc_mode == esd_pkg::MODE_HEXX)  ? esd_pkg::LIMIT_HEXX :
                   (esc_mode == esd_pkg::MODE_HEXU4) ? esd_pkg::LIMIT_HEXU4 :
                                                       esd_pkg::LIMIT_HEXU8;
        short_st = (esc_mode == esd_pkg::MODE_HEXU4) ? esd_pkg::ST_SHORT_U
                                                     : esd_pkg::ST_SHORT_W;

        if (skipping)
        begin
            if (fin)
                skipping = 1'b0;
        end
        else
        begin
            case (esc_mode)
                esd_pkg::MODE_SLASH:
                begin
                    code_acc     = 32'd0;
                    digits_taken = 4'd0;
                    if (ctl[8])
                    begin
                        expect_result({24'd0, ctl[7:0]}, 1'b0, esd_pkg::ST_OK, fin);
                        esc_mode = esd_pkg::MODE_IDLE;
                    end
                    else if (b == "x" || b == "u" || b == "U")
                    begin
                        esc_mode = (b == "x") ? esd_pkg::MODE_HEXX :
                                   (b == "u") ? esd_pkg::MODE_HEXU4 : esd_pkg::MODE_HEXU8;
                        if (fin)
                            raise_error((b == "x") ? esd_pkg::ST_EMPTY_X :
                                        (b == "u") ? esd_pkg::ST_SHORT_U :
                                                     esd_pkg::ST_SHORT_W, 1'b1);
                    end
                    else if (is_oct)
                    begin
                        code_acc     = {29'd0, b[2:0]};
                        digits_taken = 4'd1;
                        esc_mode     = esd_pkg::MODE_OCT;
                        if (fin)
                            emit_code(1'b1);
                    end
                    else
                    begin
                        raise_error(esd_pkg::ST_UNKNOWN, fin);
                    end
                end
                esd_pkg::MODE_HEXX, esd_pkg::MODE_HEXU4, esd_pkg::MODE_HEXU8:
                begin
                    if (nib[4])
                    begin
                        code_acc     = {code_acc[27:0], nib[3:0]};
                        digits_taken = digits_taken + 4'd1;
                        if (digits_taken >= lim)
                            emit_code(fin);
                        else if (fin && esc_mode == esd_pkg::MODE_HEXX)
                            emit_code(1'b1);
                        else if (fin)
                            raise_error(short_st, 1'b1);
                    end
                    else if (esc_mode == esd_pkg::MODE_HEXX)
                    begin
                        if (digits_taken == 4'd0)
                        begin
                            raise_error(esd_pkg::ST_EMPTY_X, fin);
                        end
                        else
                        begin
                            // run cut short: code point first, then the byte on its own
                            emit_code(1'b0);
                            take_plain(b, fin);
                        end
                    end
                    else
                    begin
                        raise_error(short_st, fin);
                    end
                end
                esd_pkg::MODE_OCT:
                begin
                    if (is_oct)
                    begin
                        code_acc     = {code_acc[28:0], b[2:0]};
                        digits_taken = digits_taken + 4'd1;
                        if (digits_taken >= esd_pkg::LIMIT_OCT || fin)
                            emit_code(fin);
                    end
                    else
                    begin
                        emit_code(1'b0);
                        take_plain(b, fin);
                    end
                end
                default:
                begin
                    clear_escape();
                    take_plain(b, fin);
                end
            endcase
        end
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            lit_bytes.push_back(s[i]);
    endtask

    // turn the collected bytes into requests, last one flagged final
    task automatic close_literal(input bit calm, input bit drain);
        text_req_t req;
        foreach (lit_bytes[i])
        begin
            req.text_byte  = lit_bytes[i];
            req.final_byte = (i == lit_bytes.size() - 1);
            req.gap        = calm ? 0 : $urandom_range(0, 19);
            req.drain      = drain && (i == 0);
            text_reqs.push_back(req);
        end
        lit_bytes.delete();
        literal_count++;
    endtask

    function automatic logic [7:0] random_hex_digit(input bit maxed);
        logic [7:0] v;
        v = 8'($urandom_range(0, 21));
        if (maxed)
            return "F";
        else if (v < 8'd10)
            return "0" + v;
        else if (v < 8'd16)
            return "a" + v - 8'd10;
        else
            return "A" + v - 8'd16;
    endfunction

    task automatic add_segment();
        int         n;
        bit         maxed;
        logic [7:0] b;
        maxed = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 11))
            0, 1, 2:
            begin
                b = 8'($urandom_range(0, 255));
                if (b == esd_pkg::CH_BACKSLASH)
                    b = "/";
                lit_bytes.push_back(b);
            end
            3, 4:
            begin
                case ($urandom_range(0, 10))
                    0:       b = "n";
                    1:       b = "t";
                    2:       b = "v";
                    3:       b = "b";
                    4:       b = "r";
                    5:       b = "f";
                    6:       b = "a";
                    7:       b = "\\";
                    8:       b = "?";
                    9:       b = "'";
                    default: b = "\"";
                endcase
                lit_bytes.push_back(esd_pkg::CH_BACKSLASH);
                lit_bytes.push_back(b);
            end
            5:
            begin
                n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 9);
                if (maxed)
                    n = 8;
                put_text("\\x");
                repeat (n) lit_bytes.push_back(random_hex_digit(maxed));
            end
            6:
            begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : 4;
                put_text("\\u");
                repeat (n) lit_bytes.push_back(random_hex_digit(maxed));
            end
            7:
            begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 8;
                put_text("\\U");
                repeat (n) lit_bytes.push_back(random_hex_digit(maxed));
            end
            8, 9:
            begin
                // all-sevens runs of eleven digits wrap past 32 bits
                n = maxed ? 11 : $urandom_range(1, 12);
                lit_bytes.push_back(esd_pkg::CH_BACKSLASH);
                repeat (n)
                begin
                    b      = "0";
                    b[2:0] = maxed ? 3'd7 : 3'($urandom_range(0, 7));
                    lit_bytes.push_back(b);
                end
            end
            10:
            begin
                lit_bytes.push_back(esd_pkg::CH_BACKSLASH);
                lit_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default:
            begin
                lit_bytes.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // sender: requests change on the falling edge
    always @(negedge clk)
    begin
        logic next_valid;
        if (rst_n)
        begin
            next_valid = drv_valid;
            if (drv_valid && in_fire)
                next_valid = 1'b0;
            if (!next_valid && !have_next && text_reqs.size() > 0)
            begin
                next_req  = text_reqs.pop_front();
                have_next = 1'b1;
                send_hold = next_req.gap;
            end
            if (!next_valid && have_next)
            begin
                if (send_hold > 0)
                begin
                    send_hold--;
                end
                else if (!next_req.drain || due_results.size() == 0)
                begin
                    drv_byte   <= next_req.text_byte;
                    drv_fin    <= next_req.final_byte;
                    next_valid = 1'b1;
                    have_next  = 1'b0;
                end
            end
            drv_valid <= next_valid;
        end
    end

    // receiver: stall drawn after every result, with calm stretches now and then
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
            begin
                if ($urandom_range(0, 49) == 0)
                    sink_calm = !sink_calm;
                ready_hold = sink_calm ? 0 : $urandom_range(0, 19);
            end
            if (ready_hold > 0)
            begin
                ready_hold--;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    // monitor: both handshakes sampled on the rising edge
    always @(posedge clk)
    begin
        esd_pkg::result_t want;
        if (rst_n)
        begin
            in_fire  <= text_if.valid && text_if.ready;
            out_fire <= res_if.valid && res_if.ready;
            if (res_if.valid && res_if.ready)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: result with none due, expected nothing, got value %h status %0d",
                             $time, res_if.out_value, res_if.status);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    compare_field("out_value", want.out_value, res_if.out_value);
                    compare_field("is_code_point", 32'(want.is_code_point),
                                  32'(res_if.is_code_point));
                    compare_field("status", 32'(want.status), 32'(res_if.status));
                    compare_field("end_of_string", 32'(want.end_of_string),
                                  32'(res_if.end_of_string));
                    results_checked++;
                    if (want.is_code_point)
                        code_points++;
                    if (want.status != esd_pkg::ST_OK)
                        error_results++;
                end
            end
            if (text_if.valid && text_if.ready)
            begin
                decode_byte(text_if.text_byte, text_if.final_byte);
                bytes_taken++;
            end
        end
    end

    initial
    begin
        int target;
        int n;
        bit calm;

        // directed literals
        lit_bytes.push_back(8'h00);
        lit_bytes.push_back(8'hFF);
        close_literal(1'b0, 1'b0);
        put_text("\\");
        close_literal(1'b0, 1'b0);
        put_text("\\q!z");
        close_literal(1'b0, 1'b0);
        put_text("\\xAbG");
        close_literal(1'b0, 1'b0);
        put_text("\\u12");
        close_literal(1'b0, 1'b0);
        put_text("\\U");
        close_literal(1'b0, 1'b0);
        put_text("\\101\\");
        close_literal(1'b0, 1'b0);
        put_text("\\x");
        close_literal(1'b0, 1'b1);

        // random literals, mostly well formed
        calm   = 1'b0;
        target = text_reqs.size() + 1150;
        while (text_reqs.size() < target)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
            repeat (n) add_segment();
            if ($urandom_range(0, 7) == 0)
                calm = !calm;
            close_literal(calm, (literal_count % 40) == 0);
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (text_reqs.size() != 0 || have_next || drv_valid)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("sent %0d bytes over %0d literals, both sides stalling at random",
                 bytes_taken, literal_count);
        $display("checked %0d results: %0d code points, %0d error statuses",
                 results_checked, code_points, error_results);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
